// ===== rtl/qvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvs_pkg
// Shared types and constants of the quaternion vertex skinning unit.
// ----------------------------------------------------------------------------
package qvs_pkg;

  localparam int JOINT_COUNT_DEF  = 256;
  localparam int JOINT_INDEX_SPAN = 256;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = 1;
  localparam int CNT_W       = 2;

  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 25;
  localparam int MAC_STEPS   = 32;

  localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

  localparam logic signed [63:0] ONE_Q28 = 64'sh0000_0000_1000_0000;
  localparam logic signed [63:0] HALF_Q14 = 64'sd8192;
  localparam logic signed [63:0] HALF_Q15 = 64'sd16384;
  localparam logic signed [63:0] HALF_Q24 = 64'sd8388608;

  localparam logic signed [63:0] ACC_MAX = 64'sh007F_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'shFF80_0000_0000_0000;

  localparam logic signed [55:0] OUT_MAX = 56'sh00_0000_7FFF_FFFF;
  localparam logic signed [55:0] OUT_MIN = 56'shFF_FFFF_8000_0000;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_WEIGHT = 1'b1
  } req_kind_t;

  typedef enum logic {
    RD_SQRT = 1'b0,
    RD_DIV  = 1'b1
  } rd_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L_SQ,
    ST_L_ROOTW,
    ST_L_M2,
    ST_L_ROOTM,
    ST_L_DIV,
    ST_L_WR,
    ST_W_RD,
    ST_W_LD,
    ST_W_T,
    ST_W_R,
    ST_W_C,
    ST_W_OUT
  } bk_state_t;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         joint_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [15:0]        bias;
    logic               last_weight;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    req_kind_t kind;
    logic      in_range;
    in_item_t  item;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic               clear;
    logic               neg;
    logic signed [47:0] mcand;
    logic signed [31:0] mplier;
  } mac_req_t;

  typedef struct packed {
    logic        start;
    rd_op_t      op;
    logic [63:0] rad;
    logic [15:0] num;
    logic [31:0] den;
  } rd_req_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [25:0] nx;
    logic signed [25:0] ny;
    logic signed [25:0] nz;
    logic signed [25:0] nw;
  } joint_entry_t;

endpackage

// ===== rtl/qvs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvs_front
// Accepts items, tags kind and joint range, and queues them for the back end.
// ----------------------------------------------------------------------------
module qvs_front #(
  parameter int JOINT_COUNT = qvs_pkg::JOINT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qvs_pkg::in_item_t in_data,
  output logic             q_valid,
  output qvs_pkg::cmd_t    q_data,
  input  logic             q_pop
);
  import qvs_pkg::*;

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  cmd_t             cmd;
  logic             push;
  logic             pop;

  assign in_ready = (count_r < CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_data   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    cmd.kind     = req_kind_t'(in_data.req_type);
    cmd.in_range = ({24'b0, in_data.joint_index} < 32'(JOINT_COUNT));
    cmd.item     = in_data;
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== rtl/qvs_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvs_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module qvs_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  qvs_pkg::mac_req_t  req,
  output logic               done,
  output logic signed [63:0] acc
);
  import qvs_pkg::*;

  logic signed [63:0] acc_r;
  logic signed [63:0] acc_nxt;
  logic signed [63:0] mc_r;
  logic [31:0]        mp_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic               neg_r;
  logic               done_r;
  logic               sub;

  assign done = done_r;
  assign acc  = acc_r;

  always_comb begin
    sub     = (cnt_r == 5'(MAC_STEPS - 1)) ^ neg_r;
    acc_nxt = acc_r;
    if (mp_r[0]) begin
      acc_nxt = sub ? (acc_r - mc_r) : (acc_r + mc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mc_r   <= {{16{req.mcand[47]}}, req.mcand};
        mp_r   <= req.mplier;
        neg_r  <= req.neg;
        if (req.clear) begin
          acc_r <= '0;
        end
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        mc_r  <= {mc_r[62:0], 1'b0};
        mp_r  <= {1'b0, mp_r[31:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'(MAC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/qvs_rootdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvs_rootdiv
// Iterative integer square root and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module qvs_rootdiv (
  input  logic             clk,
  input  logic             rst_n,
  input  qvs_pkg::rd_req_t req,
  output logic             done,
  output logic [31:0]      result
);
  import qvs_pkg::*;

  rd_op_t      op_r;
  logic [63:0] v_r;
  logic [63:0] v_nxt;
  logic [63:0] res_r;
  logic [63:0] res_nxt;
  logic [63:0] bit_r;
  logic [63:0] bit_nxt;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        last;
  logic [63:0] sum;
  logic [63:0] r2;

  assign done   = done_r;
  assign result = res_r[31:0];

  always_comb begin
    sum     = res_r + bit_r;
    r2      = {v_r[62:0], 1'b0};
    v_nxt   = v_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    last    = 1'b0;
    case (op_r)
      RD_SQRT: begin
        if (v_r >= sum) begin
          v_nxt   = v_r - sum;
          res_nxt = {1'b0, res_r[63:1]} + bit_r;
        end else begin
          res_nxt = {1'b0, res_r[63:1]};
        end
        bit_nxt = {2'b0, bit_r[63:2]};
        last    = (cnt_r == 5'(SQRT_STEPS - 1));
      end
      RD_DIV: begin
        if (r2 >= bit_r) begin
          v_nxt   = r2 - bit_r;
          res_nxt = {res_r[62:0], 1'b1};
        end else begin
          v_nxt   = r2;
          res_nxt = {res_r[62:0], 1'b0};
        end
        last = (cnt_r == 5'(DIV_STEPS - 1));
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= RD_SQRT;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= req.op;
        res_r  <= '0;
        if (req.op == RD_SQRT) begin
          v_r   <= req.rad;
          bit_r <= SQRT_TOP_BIT;
        end else begin
          v_r   <= {35'b0, req.num, 13'b0};
          bit_r <= {32'b0, req.den};
        end
      end else if (busy_r) begin
        v_r   <= v_nxt;
        res_r <= res_nxt;
        bit_r <= bit_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/qvs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvs_back
// Sequencer, joint store and vertex accumulators; loads joints and applies
// skinning weights through the shared multiply-accumulate and root/divide units.
// ----------------------------------------------------------------------------
module qvs_back #(
  parameter int JOINT_COUNT = qvs_pkg::JOINT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  qvs_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output qvs_pkg::out_item_t out_data
);
  import qvs_pkg::*;

  localparam int DEPTH = (JOINT_COUNT > JOINT_INDEX_SPAN) ? JOINT_INDEX_SPAN : JOINT_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bk_state_t state_r;
  bk_state_t state_nxt;

  cmd_t               cur_r;
  logic               wait_r;
  logic [1:0]         term_r;
  logic [1:0]         grp_r;
  logic signed [15:0] q_r [4];
  logic signed [25:0] n_r [4];
  logic signed [31:0] j_r [3];
  logic signed [47:0] t_r [4];
  logic signed [47:0] r_r [3];
  logic signed [63:0] tsq_r;
  logic [32:0]        m2_r;
  logic [31:0]        m_r;
  logic signed [55:0] acc_r [3];
  logic               sat_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  joint_entry_t mem [DEPTH];
  joint_entry_t mem_q_r;
  joint_entry_t wr_entry;
  logic [AW-1:0] addr;

  mac_req_t           mac_req;
  logic               mac_done;
  logic signed [63:0] mac_acc;
  rd_req_t            rd_req;
  logic               rd_done;
  logic [31:0]        rd_result;

  logic               mem_we;
  logic               out_push;
  logic               term_last;
  logic               grp_last;
  logic [1:0]         o1;
  logic [1:0]         o2;
  logic [1:0]         asel;
  logic [1:0]         bsel;
  logic signed [63:0] tsq_next;
  logic signed [63:0] rnd14;
  logic signed [63:0] rnd15;
  logic signed [63:0] rnd24;
  logic signed [63:0] acc_sum;
  logic signed [55:0] acc_sat;
  logic               acc_ov;
  logic               div_neg;
  logic signed [25:0] quot;
  logic [32:0]        cx;
  logic [32:0]        cy;
  logic [32:0]        cz;

  function automatic logic [1:0] next3(input logic [1:0] o);
    return (o == 2'd2) ? 2'd0 : o + 2'd1;
  endfunction

  function automatic logic [1:0] prev3(input logic [1:0] o);
    return (o == 2'd0) ? 2'd2 : o - 2'd1;
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [32:0] clamp32(input logic signed [55:0] v);
    if (v > OUT_MAX) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < OUT_MIN) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic signed [31:0] pos_sel(input in_item_t it, input logic [1:0] i);
    logic signed [31:0] p;
    case (i)
      2'd0:    p = it.pos_x;
      2'd1:    p = it.pos_y;
      2'd2:    p = it.pos_z;
      default: p = '0;
    endcase
    return p;
  endfunction

  qvs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  qvs_rootdiv u_rootdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (rd_req),
    .done   (rd_done),
    .result (rd_result)
  );

  assign addr      = cur_r.item.joint_index[AW-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tsq_next = ONE_Q28 - mac_acc;
  assign rnd14    = (mac_acc + HALF_Q14) >>> 14;
  assign rnd15    = (mac_acc + HALF_Q15) >>> 15;
  assign rnd24    = (mac_acc + HALF_Q24) >>> 24;
  assign acc_sum  = {{8{acc_r[grp_r][55]}}, acc_r[grp_r]} + rnd15;
  assign acc_ov   = (acc_sum > ACC_MAX) || (acc_sum < ACC_MIN);
  assign acc_sat  = (acc_sum > ACC_MAX) ? ACC_MAX[55:0] :
                    (acc_sum < ACC_MIN) ? ACC_MIN[55:0] : acc_sum[55:0];
  assign div_neg  = q_r[grp_r][15] ^ (grp_r != 2'd3);
  assign quot     = 26'(rd_result);
  assign cx       = clamp32(acc_r[0]);
  assign cy       = clamp32(acc_r[1]);
  assign cz       = clamp32(acc_r[2]);

  always_comb begin
    wr_entry.px = cur_r.item.pos_x;
    wr_entry.py = cur_r.item.pos_y;
    wr_entry.pz = cur_r.item.pos_z;
    wr_entry.qx = q_r[0];
    wr_entry.qy = q_r[1];
    wr_entry.qz = q_r[2];
    wr_entry.qw = q_r[3];
    wr_entry.nx = n_r[0];
    wr_entry.ny = n_r[1];
    wr_entry.nz = n_r[2];
    wr_entry.nw = n_r[3];
  end

  always_comb begin
    q_pop     = 1'b0;
    mac_req   = '0;
    rd_req    = '0;
    mem_we    = 1'b0;
    out_push  = 1'b0;
    term_last = 1'b0;
    grp_last  = 1'b0;
    o1        = next3(grp_r);
    o2        = prev3(grp_r);
    asel      = '0;
    bsel      = '0;
    case (state_r)
      ST_IDLE: begin
        q_pop = q_valid;
      end
      ST_L_SQ: begin
        mac_req.start  = !wait_r;
        mac_req.clear  = (term_r == 2'd0);
        mac_req.mcand  = {{32{q_r[term_r][15]}}, q_r[term_r]};
        mac_req.mplier = {{16{q_r[term_r][15]}}, q_r[term_r]};
        term_last      = (term_r == 2'd2);
        grp_last       = 1'b1;
      end
      ST_L_ROOTW: begin
        rd_req.start = !wait_r;
        rd_req.op    = RD_SQRT;
        rd_req.rad   = tsq_r;
        grp_last     = 1'b1;
      end
      ST_L_M2: begin
        mac_req.start  = !wait_r;
        mac_req.mcand  = {{32{q_r[3][15]}}, q_r[3]};
        mac_req.mplier = {{16{q_r[3][15]}}, q_r[3]};
        term_last      = 1'b1;
        grp_last       = 1'b1;
      end
      ST_L_ROOTM: begin
        rd_req.start = !wait_r;
        rd_req.op    = RD_SQRT;
        rd_req.rad   = {3'b0, m2_r, 28'b0};
        grp_last     = 1'b1;
      end
      ST_L_DIV: begin
        rd_req.start = !wait_r;
        rd_req.op    = RD_DIV;
        rd_req.num   = mag16(q_r[grp_r]);
        rd_req.den   = m_r;
        grp_last     = (grp_r == 2'd3);
      end
      ST_L_WR: begin
        mem_we = 1'b1;
      end
      ST_W_T: begin
        if (grp_r == 2'd3) begin
          asel        = term_r;
          bsel        = term_r;
          mac_req.neg = 1'b1;
        end else begin
          case (term_r)
            2'd0: begin
              asel = 2'd3;
              bsel = grp_r;
            end
            2'd1: begin
              asel = o1;
              bsel = o2;
            end
            default: begin
              asel        = o2;
              bsel        = o1;
              mac_req.neg = 1'b1;
            end
          endcase
        end
        mac_req.start  = !wait_r;
        mac_req.clear  = (term_r == 2'd0);
        mac_req.mcand  = {{32{q_r[asel][15]}}, q_r[asel]};
        mac_req.mplier = pos_sel(cur_r.item, bsel);
        term_last      = (term_r == 2'd2);
        grp_last       = (grp_r == 2'd3);
      end
      ST_W_R: begin
        case (term_r)
          2'd0: begin
            asel = grp_r;
            bsel = 2'd3;
          end
          2'd1: begin
            asel = 2'd3;
            bsel = grp_r;
          end
          2'd2: begin
            asel = o1;
            bsel = o2;
          end
          default: begin
            asel        = o2;
            bsel        = o1;
            mac_req.neg = 1'b1;
          end
        endcase
        mac_req.start  = !wait_r;
        mac_req.clear  = (term_r == 2'd0);
        mac_req.mcand  = t_r[asel];
        mac_req.mplier = {{6{n_r[bsel][25]}}, n_r[bsel]};
        term_last      = (term_r == 2'd3);
        grp_last       = (grp_r == 2'd2);
      end
      ST_W_C: begin
        mac_req.start  = !wait_r;
        mac_req.clear  = 1'b1;
        mac_req.mcand  = {{16{j_r[grp_r][31]}}, j_r[grp_r]} + r_r[grp_r];
        mac_req.mplier = {16'b0, cur_r.item.bias};
        term_last      = 1'b1;
        grp_last       = (grp_r == 2'd2);
      end
      ST_W_OUT: begin
        out_push = !out_valid_r || out_ready;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_data.kind == REQ_LOAD) begin
            state_nxt = q_data.in_range ? ST_L_SQ : ST_IDLE;
          end else begin
            state_nxt = ST_W_RD;
          end
        end
      end
      ST_L_SQ: begin
        if (mac_done && term_last) begin
          state_nxt = tsq_next[63] ? ST_L_M2 : ST_L_ROOTW;
        end
      end
      ST_L_ROOTW: begin
        if (rd_done) begin
          state_nxt = ST_L_M2;
        end
      end
      ST_L_M2: begin
        if (mac_done) begin
          state_nxt = (mac_acc == '0) ? ST_L_WR : ST_L_ROOTM;
        end
      end
      ST_L_ROOTM: begin
        if (rd_done) begin
          state_nxt = ST_L_DIV;
        end
      end
      ST_L_DIV: begin
        if (rd_done && grp_last) begin
          state_nxt = ST_L_WR;
        end
      end
      ST_L_WR: begin
        state_nxt = ST_IDLE;
      end
      ST_W_RD: begin
        state_nxt = ST_W_LD;
      end
      ST_W_LD: begin
        state_nxt = ST_W_T;
      end
      ST_W_T: begin
        if (mac_done && term_last && grp_last) begin
          state_nxt = ST_W_R;
        end
      end
      ST_W_R: begin
        if (mac_done && term_last && grp_last) begin
          state_nxt = ST_W_C;
        end
      end
      ST_W_C: begin
        if (mac_done && grp_last) begin
          state_nxt = cur_r.item.last_weight ? ST_W_OUT : ST_IDLE;
        end
      end
      ST_W_OUT: begin
        if (out_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= 1'b0;
      term_r      <= '0;
      grp_r       <= '0;
      acc_r[0]    <= '0;
      acc_r[1]    <= '0;
      acc_r[2]    <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mac_req.start || rd_req.start) begin
        wait_r <= 1'b1;
      end else if (mac_done || rd_done) begin
        wait_r <= 1'b0;
      end
      if (mac_done) begin
        if (term_last) begin
          term_r <= '0;
          grp_r  <= grp_last ? 2'd0 : grp_r + 2'd1;
        end else begin
          term_r <= term_r + 2'd1;
        end
      end
      if (rd_done) begin
        grp_r <= grp_last ? 2'd0 : grp_r + 2'd1;
      end
      if (q_pop) begin
        cur_r <= q_data;
        q_r[0] <= q_data.item.quat_x;
        q_r[1] <= q_data.item.quat_y;
        q_r[2] <= q_data.item.quat_z;
        q_r[3] <= '0;
      end
      case (state_r)
        ST_L_SQ: begin
          if (mac_done && term_last) begin
            tsq_r <= tsq_next;
          end
        end
        ST_L_ROOTW: begin
          if (rd_done) begin
            q_r[3] <= -$signed(rd_result[15:0]);
          end
        end
        ST_L_M2: begin
          if (mac_done) begin
            m2_r   <= mac_acc[32:0];
            n_r[0] <= '0;
            n_r[1] <= '0;
            n_r[2] <= '0;
            n_r[3] <= '0;
          end
        end
        ST_L_ROOTM: begin
          if (rd_done) begin
            m_r <= rd_result;
          end
        end
        ST_L_DIV: begin
          if (rd_done) begin
            n_r[grp_r] <= div_neg ? -quot : quot;
          end
        end
        ST_W_LD: begin
          if (cur_r.in_range) begin
            j_r[0] <= mem_q_r.px;
            j_r[1] <= mem_q_r.py;
            j_r[2] <= mem_q_r.pz;
            q_r[0] <= mem_q_r.qx;
            q_r[1] <= mem_q_r.qy;
            q_r[2] <= mem_q_r.qz;
            q_r[3] <= mem_q_r.qw;
            n_r[0] <= mem_q_r.nx;
            n_r[1] <= mem_q_r.ny;
            n_r[2] <= mem_q_r.nz;
            n_r[3] <= mem_q_r.nw;
          end else begin
            j_r[0] <= '0;
            j_r[1] <= '0;
            j_r[2] <= '0;
            q_r[0] <= '0;
            q_r[1] <= '0;
            q_r[2] <= '0;
            q_r[3] <= '0;
            n_r[0] <= '0;
            n_r[1] <= '0;
            n_r[2] <= '0;
            n_r[3] <= '0;
          end
        end
        ST_W_T: begin
          if (mac_done && term_last) begin
            t_r[grp_r] <= rnd14[47:0];
          end
        end
        ST_W_R: begin
          if (mac_done && term_last) begin
            r_r[grp_r] <= rnd24[47:0];
          end
        end
        ST_W_C: begin
          if (mac_done) begin
            acc_r[grp_r] <= acc_sat;
            if (acc_ov) begin
              sat_r <= 1'b1;
            end
          end
        end
        ST_W_OUT: begin
          if (out_push) begin
            acc_r[0] <= '0;
            acc_r[1] <= '0;
            acc_r[2] <= '0;
            sat_r    <= 1'b0;
          end
        end
        default: begin
          sat_r <= sat_r;
        end
      endcase
      if (out_push) begin
        out_valid_r          <= 1'b1;
        out_data_r.vert_x    <= cx[31:0];
        out_data_r.vert_y    <= cy[31:0];
        out_data_r.vert_z    <= cz[31:0];
        out_data_r.saturated <= sat_r || cx[32] || cy[32] || cz[32];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wr_entry;
    end
    mem_q_r <= mem[addr];
  end

endmodule

// ===== rtl/quaternion_vertex_skinning_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vertex_skinning_unit
// Linear blend skinning with quaternion joints: joint store plus accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of request items. A load item writes one joint
//           (position, orientation; w and the normalized conjugate are derived
//           and stored). A weight item adds one biased influence to the vertex.
//   out_* : valid/ready channel; one vertex item per weight item whose
//           last_weight is set, Q15.16, clamped, with a saturation flag.
// Processing: items are processed one at a time. A weight item runs 27
//   multiply-accumulate terms through the bit-serial multiplier; an in-range
//   load item runs four multiply-accumulate terms, up to two 32-step roots
//   and up to four 25-step divides.
//   A two-entry queue takes new items while the back end works.
// Reset: rst_n low clears the queue, accumulators and output valid flag; the
//   joint store holds no defined contents until loaded.
// Stall: a vertex waits in the output register while out_ready is low; the
//   back end holds before emitting the next vertex until that one is taken.
// ----------------------------------------------------------------------------
module quaternion_vertex_skinning_unit #(
  parameter int JOINT_COUNT = qvs_pkg::JOINT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qvs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qvs_pkg::out_item_t out_data
);
  import qvs_pkg::*;

  logic q_valid;
  cmd_t q_data;
  logic q_pop;

  qvs_front #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  qvs_back #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("reset did not clear the channels");

  a_pop_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.kind == REQ_WEIGHT) |=> !q_pop)
    else $error("weight item popped without processing");

endmodule
